[rtl/core/cubeh_pkg.sv]
// ============================================================================
// cubeh_pkg
// Shared types and constants for the byte-serial CubeHash engine.
// ============================================================================
package cubeh_pkg;

    // State geometry
    localparam int unsigned NUM_WORDS  = 32;
    localparam int unsigned HALF_WORDS = 16;
    localparam int unsigned WORD_W     = 32;

    // Transform counts for start and finish (finish: one plus ten more)
    localparam int unsigned XF_W          = 4;
    localparam logic [XF_W-1:0] XF_INIT   = 4'd10;
    localparam logic [XF_W-1:0] XF_FINISH = 4'd11;
    localparam logic [XF_W-1:0] XF_ONE    = 4'd1;

    // Digest length limits and pad byte
    localparam logic [6:0] DIGEST_MIN = 7'd1;
    localparam logic [6:0] DIGEST_MAX = 7'd64;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // Half-round rotations
    localparam int unsigned ROT_A = 7;
    localparam int unsigned ROT_B = 11;

    typedef logic [WORD_W-1:0] cubeh_word_t;
    typedef cubeh_word_t cubeh_words_t [NUM_WORDS];

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_ABSORB = 2'd1,
        OP_FINISH = 2'd2
    } cubeh_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FLIP,
        ST_LOAD_OUT,
        ST_EMIT
    } cubeh_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic init;      // clear state, load header words, rewind position
        logic absorb;    // xor message byte, advance position
        logic pad;       // xor pad byte at current position
        logic half;      // run one half round
        logic phase;     // half-round select: 0 first, 1 second
        logic flip;      // flip low bit of last word
        logic out_load;  // load digest byte zero
        logic out_next;  // load next digest byte
    } cubeh_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic block_full;  // an absorb now would fill the block
        logic out_last;    // digest byte on the output is the final one
    } cubeh_status_t;

endpackage

[rtl/core/cubeh_datapath.sv]
// ============================================================================
// cubeh_datapath
// State words, byte position, half-round unit and digest output register.
// ============================================================================
module cubeh_datapath #(
    parameter int unsigned ROUNDS      = 16,
    parameter int unsigned BLOCK_BYTES = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cubeh_pkg::cubeh_cmd_t cmd,
    output cubeh_pkg::cubeh_status_t status,
    input  logic [7:0]            msg_byte,
    input  logic                  cfg_wr_en,
    input  logic [6:0]            cfg_wr_data,
    output logic [7:0]            digest_byte,
    output logic                  last_byte
);

    cubeh_pkg::cubeh_words_t state_reg;
    cubeh_pkg::cubeh_words_t state_next;
    cubeh_pkg::cubeh_words_t half_res;
    cubeh_pkg::cubeh_word_t  hi_sum [cubeh_pkg::HALF_WORDS];

    logic [6:0] pos_reg;
    logic [6:0] pos_next;
    logic [7:0] pos_inc;
    logic [6:0] dlen_reg;
    logic [6:0] dlen_clamped;
    logic [7:0] xor_byte;
    logic [5:0] idx_reg;
    logic [5:0] sel_idx;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    cubeh_pkg::cubeh_word_t sel_word;

    // Clamp digest length to 1..64
    always_comb begin
        priority if (dlen_reg < cubeh_pkg::DIGEST_MIN) begin
            dlen_clamped = cubeh_pkg::DIGEST_MIN;
        end else if (dlen_reg > cubeh_pkg::DIGEST_MAX) begin
            dlen_clamped = cubeh_pkg::DIGEST_MAX;
        end else begin
            dlen_clamped = dlen_reg;
        end
    end

    // Block-fill check for the next absorb
    assign pos_inc           = {1'b0, pos_reg} + 8'd1;
    assign status.block_full = (pos_inc >= 8'(BLOCK_BYTES));

    // One half round: add, swap and rotate, xor, swap
    always_comb begin
        for (int i = 0; i < cubeh_pkg::HALF_WORDS; i++) begin
            hi_sum[i] = state_reg[i + cubeh_pkg::HALF_WORDS] + state_reg[i];
        end
        for (int j = 0; j < cubeh_pkg::HALF_WORDS; j++) begin
            if (cmd.phase) begin
                half_res[j] = {state_reg[j ^ 4][cubeh_pkg::WORD_W-cubeh_pkg::ROT_B-1:0],
                               state_reg[j ^ 4][cubeh_pkg::WORD_W-1:
                                                cubeh_pkg::WORD_W-cubeh_pkg::ROT_B]}
                              ^ hi_sum[j];
                half_res[j + cubeh_pkg::HALF_WORDS] = hi_sum[j ^ 1];
            end else begin
                half_res[j] = {state_reg[j ^ 8][cubeh_pkg::WORD_W-cubeh_pkg::ROT_A-1:0],
                               state_reg[j ^ 8][cubeh_pkg::WORD_W-1:
                                                cubeh_pkg::WORD_W-cubeh_pkg::ROT_A]}
                              ^ hi_sum[j];
                half_res[j + cubeh_pkg::HALF_WORDS] = hi_sum[j ^ 2];
            end
        end
    end

    // Select next state contents
    assign xor_byte = cmd.absorb ? msg_byte : cubeh_pkg::PAD_BYTE;

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        priority if (cmd.init) begin
            for (int k = 0; k < cubeh_pkg::NUM_WORDS; k++) begin
                state_next[k] = '0;
            end
            state_next[0] = 32'(dlen_clamped);
            state_next[1] = 32'(BLOCK_BYTES);
            state_next[2] = 32'(ROUNDS);
            pos_next      = '0;
        end else if (cmd.absorb || cmd.pad) begin
            state_next[pos_reg[6:2]] = state_reg[pos_reg[6:2]]
                                       ^ (32'(xor_byte) << {pos_reg[1:0], 3'b000});
            if (cmd.absorb) begin
                pos_next = status.block_full ? 7'd0 : pos_inc[6:0];
            end
        end else if (cmd.half) begin
            state_next = half_res;
        end else if (cmd.flip) begin
            state_next[cubeh_pkg::NUM_WORDS-1] =
                state_reg[cubeh_pkg::NUM_WORDS-1] ^ 32'd1;
        end
    end

    // Hold state, position and length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < cubeh_pkg::NUM_WORDS; k++) begin
                state_reg[k] <= '0;
            end
            pos_reg  <= '0;
            dlen_reg <= cubeh_pkg::DIGEST_MAX;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (cfg_wr_en) begin
                dlen_reg <= cfg_wr_data;
            end
        end
    end

    // Digest byte k is byte k%4 of word k/4
    assign sel_idx  = cmd.out_load ? 6'd0 : idx_reg;
    assign sel_word = state_reg[{1'b0, sel_idx[5:2]}];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            out_last_reg <= 1'b0;
        end else if (cmd.out_load || cmd.out_next) begin
            idx_reg      <= sel_idx + 6'd1;
            out_last_reg <= (sel_idx == 6'(dlen_clamped - 7'd1));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load || cmd.out_next) begin
            out_byte_reg <= sel_word[{sel_idx[1:0], 3'b000} +: 8];
        end
    end

    assign status.out_last = out_last_reg;
    assign digest_byte     = out_byte_reg;
    assign last_byte       = out_last_reg;

endmodule

[rtl/core/cubeh_ctrl.sv]
// ============================================================================
// cubeh_ctrl
// Sequencer: request decode, round and transform counting, digest emission.
// ============================================================================
module cubeh_ctrl #(
    parameter int unsigned ROUNDS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_opcode,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cubeh_pkg::cubeh_cmd_t    cmd,
    input  cubeh_pkg::cubeh_status_t status
);

    localparam int unsigned RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    cubeh_pkg::cubeh_state_t state_reg, state_next;
    logic [RND_W-1:0]          rnd_reg, rnd_next;
    logic                      phase_reg, phase_next;
    logic [cubeh_pkg::XF_W-1:0] xf_left_reg, xf_left_next;
    logic                      fin_reg, fin_next;

    // State and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cubeh_pkg::ST_IDLE;
            rnd_reg     <= '0;
            phase_reg   <= 1'b0;
            xf_left_reg <= '0;
            fin_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            phase_reg   <= phase_next;
            xf_left_reg <= xf_left_next;
            fin_reg     <= fin_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        phase_next   = phase_reg;
        xf_left_next = xf_left_reg;
        fin_next     = fin_reg;
        cmd          = '0;
        cmd.phase    = phase_reg;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        unique case (state_reg)
            cubeh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (cubeh_pkg::cubeh_op_t'(s_opcode))
                        cubeh_pkg::OP_START: begin
                            cmd.init     = 1'b1;
                            xf_left_next = cubeh_pkg::XF_INIT;
                            fin_next     = 1'b0;
                            state_next   = cubeh_pkg::ST_ROUND;
                        end
                        cubeh_pkg::OP_ABSORB: begin
                            cmd.absorb = 1'b1;
                            if (status.block_full) begin
                                xf_left_next = cubeh_pkg::XF_ONE;
                                fin_next     = 1'b0;
                                state_next   = cubeh_pkg::ST_ROUND;
                            end
                        end
                        cubeh_pkg::OP_FINISH: begin
                            cmd.pad      = 1'b1;
                            xf_left_next = cubeh_pkg::XF_FINISH;
                            fin_next     = 1'b1;
                            state_next   = cubeh_pkg::ST_ROUND;
                        end
                        default: begin
                            // drop the unused opcode
                        end
                    endcase
                end
            end
            cubeh_pkg::ST_ROUND: begin
                cmd.half   = 1'b1;
                phase_next = ~phase_reg;
                if (phase_reg) begin
                    if (rnd_reg == RND_LAST) begin
                        // transform done
                        rnd_next     = '0;
                        xf_left_next = xf_left_reg - cubeh_pkg::XF_ONE;
                        priority if (fin_reg && xf_left_reg == cubeh_pkg::XF_FINISH) begin
                            state_next = cubeh_pkg::ST_FLIP;
                        end else if (xf_left_reg == cubeh_pkg::XF_ONE) begin
                            state_next = fin_reg ? cubeh_pkg::ST_LOAD_OUT
                                                 : cubeh_pkg::ST_IDLE;
                        end else begin
                            state_next = cubeh_pkg::ST_ROUND;
                        end
                    end else begin
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                end
            end
            cubeh_pkg::ST_FLIP: begin
                cmd.flip   = 1'b1;
                state_next = cubeh_pkg::ST_ROUND;
            end
            cubeh_pkg::ST_LOAD_OUT: begin
                cmd.out_load = 1'b1;
                state_next   = cubeh_pkg::ST_EMIT;
            end
            cubeh_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.out_last) begin
                        state_next = cubeh_pkg::ST_IDLE;
                    end else begin
                        cmd.out_next = 1'b1;
                    end
                end
            end
            default: begin
                state_next = cubeh_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while digest pending");

    a_round_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cubeh_pkg::ST_ROUND) |-> (xf_left_reg != '0))
        else $error("round running with no transform left");

    a_finish_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == cubeh_pkg::OP_FINISH)
        |=> (state_reg == cubeh_pkg::ST_ROUND && fin_reg))
        else $error("finish did not start transforms");

    a_emit_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !status.out_last) |=> m_valid)
        else $error("digest stream ended early");

    a_flip_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cubeh_pkg::ST_FLIP) |-> (fin_reg && xf_left_reg == cubeh_pkg::XF_INIT))
        else $error("flip outside finish sequence");
`endif

endmodule

[rtl/core/cubehash_engine.sv]
// ============================================================================
// cubehash_engine
// Byte-serial CubeHash engine over a 1024-bit state of 32 words.
// ============================================================================
//  channel | ports                            | carries
//  --------+----------------------------------+------------------------------
//  s_      | s_valid s_ready s_opcode s_msg   | start / absorb / finish request
//  m_      | m_valid m_ready m_digest_byte .. | digest bytes, last flag
//  cfg_    | cfg_wr_en cfg_wr_data            | digest length in bytes
//
//  One request at a time; a transform is 2*ROUNDS half rounds on the shared
//  round unit. Start runs ten transforms. Absorb xors in one byte and runs
//  one transform on a full block. Finish pads, runs one transform, flips the
//  low bit of the last word, runs ten more, then emits one digest byte per cycle while
//  m_ready is high. s_ready is low from acceptance until the last digest byte
//  is taken; a stalled m_ready holds the current byte. Synchronous reset
//  clears the state words, byte position and sets the digest length to 64.
// ============================================================================
module cubehash_engine #(
    parameter int unsigned ROUNDS      = 16,
    parameter int unsigned BLOCK_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_msg_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_digest_byte,
    output logic       m_last_byte,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data
);

    cubeh_pkg::cubeh_cmd_t    cmd;
    cubeh_pkg::cubeh_status_t status;

    // Sequencer
    cubeh_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // State and round unit
    cubeh_datapath #(
        .ROUNDS      (ROUNDS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .msg_byte    (s_msg_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .digest_byte (m_digest_byte),
        .last_byte   (m_last_byte)
    );

endmodule
